@@ rtl/tlw_pkg.sv @@
`default_nettype none

package tlw_pkg;

  localparam int unsigned RunSlotsDef = 256;
  localparam int unsigned MaxRes      = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 12;

  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTilde   = 8'h7E;
  localparam logic [7:0] CharNewline = 8'h0A;

  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_HALT  = 2'd2
  } tlw_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_WRAP_WIDTH  = 3'd2,
    CFG_STOP_HEIGHT = 3'd3,
    CFG_LINE_GAP    = 3'd4,
    CFG_GLYPH_W     = 3'd5,
    CFG_GLYPH_H     = 3'd6
  } tlw_cfg_idx_e;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [11:0] wrap_width;
    logic [11:0] stop_height;
    logic [7:0]  line_gap;
    logic [6:0]  glyph_w;
    logic [6:0]  glyph_h;
  } tlw_cfg_t;

  typedef struct packed {
    tlw_kind_e   kind;
    logic [6:0]  glyph_code;
    logic [7:0]  slot;
    logic [15:0] run_x;
    logic [15:0] run_y;
    logic [8:0]  run_length;
    logic        last;
  } tlw_res_t;

  typedef struct packed {
    tlw_res_t [MaxRes-1:0] res;
    logic [1:0]            cnt;
  } tlw_bundle_t;

  function automatic logic [15:0] sat16(input logic [16:0] s);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic tlw_res_t mk_glyph(input logic [6:0] code, input logic [7:0] slot);
    tlw_res_t r;
    r            = '0;
    r.kind       = KIND_GLYPH;
    r.glyph_code = code;
    r.slot       = slot;
    return r;
  endfunction

  function automatic tlw_res_t mk_flush(input logic [15:0] x, input logic [15:0] y,
                                        input logic [8:0] len);
    tlw_res_t r;
    r            = '0;
    r.kind       = KIND_FLUSH;
    r.run_x      = x;
    r.run_y      = y;
    r.run_length = len;
    return r;
  endfunction

  function automatic tlw_res_t mk_halt();
    tlw_res_t r;
    r      = '0;
    r.kind = KIND_HALT;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tlw_char_if.sv @@
`default_nettype none

interface tlw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ rtl/tlw_res_if.sv @@
`default_nettype none

interface tlw_res_if;
  logic                valid;
  logic                ready;
  tlw_pkg::tlw_kind_e  kind;
  logic [6:0]          glyph_code;
  logic [7:0]          slot;
  logic [15:0]         run_x;
  logic [15:0]         run_y;
  logic [8:0]          run_length;
  logic                last;

  modport source (output valid, output kind, output glyph_code, output slot, output run_x,
                  output run_y, output run_length, output last, input ready);
  modport sink (input valid, input kind, input glyph_code, input slot, input run_x,
                input run_y, input run_length, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/tlw_core.sv @@
`default_nettype none

module tlw_core #(
  parameter int unsigned RunSlots = tlw_pkg::RunSlotsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  tlw_pkg::tlw_cfg_t     cfg_i,
  tlw_char_if.sink              char_i,
  input  wire                   q_ready_i,
  output logic                  bundle_valid_o,
  output tlw_pkg::tlw_bundle_t  bundle_o
);
  import tlw_pkg::*;

  localparam int unsigned CntW = $clog2(RunSlots + 1);
  localparam logic [CntW-1:0] RunFull = CntW'(RunSlots);

  logic [15:0]     pen_x_q, pen_x_d;
  logic [15:0]     pen_y_q, pen_y_d;
  logic [15:0]     start_x_q, start_x_d;
  logic [CntW-1:0] count_q, count_d;
  logic            halted_q, halted_d;
  logic            in_text_q, in_text_d;

  logic            accept;
  logic            do_char;
  logic [1:0]      n;
  tlw_res_t [MaxRes-1:0] res;
  logic [7:0]      c;

  function automatic logic stop_hit(input logic [15:0] y, input tlw_cfg_t cfg);
    return (cfg.stop_height != '0) &&
           ($signed({2'b00, y}) - $signed({6'b0, cfg.origin_y}) >
            $signed({6'b0, cfg.stop_height}));
  endfunction

  function automatic logic [15:0] down_line(input logic [15:0] y, input tlw_cfg_t cfg);
    return sat16({1'b0, y} + 17'(cfg.glyph_h) + 17'(cfg.line_gap));
  endfunction

  assign accept         = char_i.valid && q_ready_i;
  assign char_i.ready   = q_ready_i;
  assign c              = char_i.char_code;
  assign bundle_valid_o = accept && (n != 2'd0);

  always_comb begin
    pen_x_d   = in_text_q ? pen_x_q : 16'(cfg_i.origin_x);
    pen_y_d   = in_text_q ? pen_y_q : 16'(cfg_i.origin_y);
    start_x_d = in_text_q ? start_x_q : 16'(cfg_i.origin_x);
    count_d   = in_text_q ? count_q : '0;
    halted_d  = in_text_q ? halted_q : 1'b0;
    in_text_d = 1'b1;
    do_char   = 1'b0;
    n         = 2'd0;
    res       = '0;

    if (!halted_d) begin
      if (stop_hit(pen_y_d, cfg_i)) begin
        res[n]   = mk_halt();
        n        = n + 2'd1;
        halted_d = 1'b1;
      end else if ((cfg_i.wrap_width != '0) &&
                   ($signed({3'b0, pen_x_d}) - $signed({7'b0, cfg_i.origin_x}) +
                    $signed({12'b0, cfg_i.glyph_w}) > $signed({7'b0, cfg_i.wrap_width})))
      begin
        if (count_d == '0) begin
          res[n]   = mk_halt();
          n        = n + 2'd1;
          halted_d = 1'b1;
        end else begin
          res[n]    = mk_flush(start_x_d, pen_y_d, 9'(count_d));
          n         = n + 2'd1;
          pen_x_d   = 16'(cfg_i.origin_x);
          start_x_d = 16'(cfg_i.origin_x);
          pen_y_d   = down_line(pen_y_d, cfg_i);
          count_d   = '0;
          if (stop_hit(pen_y_d, cfg_i) ||
              ((cfg_i.wrap_width != '0) && ({5'b0, cfg_i.glyph_w} > cfg_i.wrap_width))) begin
            res[n]   = mk_halt();
            n        = n + 2'd1;
            halted_d = 1'b1;
          end else begin
            do_char = 1'b1;
          end
        end
      end else if (count_d >= RunFull) begin
        res[n]    = mk_flush(start_x_d, pen_y_d, 9'(count_d));
        n         = n + 2'd1;
        start_x_d = pen_x_d;
        count_d   = '0;
        do_char   = 1'b1;
      end else begin
        do_char = 1'b1;
      end

      if (do_char) begin
        if (c == CharNewline) begin
          res[n]    = mk_flush(start_x_d, pen_y_d, 9'(count_d));
          n         = n + 2'd1;
          pen_x_d   = 16'(cfg_i.origin_x);
          start_x_d = 16'(cfg_i.origin_x);
          pen_y_d   = down_line(pen_y_d, cfg_i);
          count_d   = '0;
        end else if ((c >= CharSpace) && (c <= CharTilde)) begin
          res[n]  = mk_glyph(c[6:0], 8'(count_d));
          n       = n + 2'd1;
          count_d = count_d + CntW'(1);
          pen_x_d = sat16({1'b0, pen_x_d} + 17'(cfg_i.glyph_w));
        end
      end

      if (char_i.end_of_text && !halted_d && (count_d != '0)) begin
        res[n] = mk_flush(start_x_d, pen_y_d, 9'(count_d));
        n      = n + 2'd1;
      end
    end

    if (char_i.end_of_text) begin
      count_d   = '0;
      halted_d  = 1'b0;
      in_text_d = 1'b0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  assign bundle_o.res = res;
  assign bundle_o.cnt = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      start_x_q <= '0;
      count_q   <= '0;
      halted_q  <= 1'b0;
      in_text_q <= 1'b0;
    end else if (accept) begin
      pen_x_q   <= pen_x_d;
      pen_y_q   <= pen_y_d;
      start_x_q <= start_x_d;
      count_q   <= count_d;
      halted_q  <= halted_d;
      in_text_q <= in_text_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tlw_outq.sv @@
`default_nettype none

module tlw_outq (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  tlw_pkg::tlw_bundle_t  bundle_i,
  output logic                  ready_o,
  tlw_res_if.source             res_o
);
  import tlw_pkg::*;

  tlw_bundle_t bund_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;
  logic [1:0]  cursor_q;
  logic        pop, take;
  tlw_res_t    head;

  assign ready_o  = (fill_q != 2'd2);
  assign head     = bund_q[rd_ptr_q].res[cursor_q];
  assign take     = res_o.valid && res_o.ready;
  assign pop      = take && (cursor_q == (bund_q[rd_ptr_q].cnt - 2'd1));

  assign res_o.valid      = (fill_q != 2'd0);
  assign res_o.kind       = head.kind;
  assign res_o.glyph_code = head.glyph_code;
  assign res_o.slot       = head.slot;
  assign res_o.run_x      = head.run_x;
  assign res_o.run_y      = head.run_y;
  assign res_o.run_length = head.run_length;
  assign res_o.last       = head.last;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bund_q[wr_ptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
      cursor_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        cursor_q <= 2'd0;
      end else if (take) begin
        cursor_q <= cursor_q + 2'd1;
      end
      if (push_i && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/text_line_wrap_layout.sv @@
// An accepted request's results are registered in the result queue and offered in order.
// One request per cycle while the queue has room; each result is held until the output takes it.
// A two-entry result queue sits behind the layout logic; input ready is low while both are full.
// Reset clears the layout state and the queue and loads the register defaults
// (glyph cell 6 by 12, everything else zero).
`default_nettype none

module text_line_wrap_layout #(
  parameter int unsigned RunSlots = tlw_pkg::RunSlotsDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [tlw_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [tlw_pkg::CfgDataW-1:0]   cfg_data_i,
  tlw_char_if.sink                      char_i,
  tlw_res_if.source                     res_o
);
  import tlw_pkg::*;

  tlw_cfg_t    cfg_q;
  tlw_bundle_t bundle;
  logic        bundle_valid;
  logic        q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{origin_x: 12'd0, origin_y: 12'd0, wrap_width: 12'd0, stop_height: 12'd0,
                 line_gap: 8'd0, glyph_w: 7'd6, glyph_h: 7'd12};
    end else if (cfg_we_i) begin
      unique case (tlw_cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:    cfg_q.origin_x    <= cfg_data_i;
        CFG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_data_i;
        CFG_WRAP_WIDTH:  cfg_q.wrap_width  <= cfg_data_i;
        CFG_STOP_HEIGHT: cfg_q.stop_height <= cfg_data_i;
        CFG_LINE_GAP:    cfg_q.line_gap    <= cfg_data_i[7:0];
        CFG_GLYPH_W:     cfg_q.glyph_w     <= cfg_data_i[6:0];
        CFG_GLYPH_H:     cfg_q.glyph_h     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  tlw_core #(
    .RunSlots(RunSlots)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .char_i         (char_i),
    .q_ready_i      (q_ready),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  tlw_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (bundle_valid),
    .bundle_i (bundle),
    .ready_o  (q_ready),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_text_line_wrap_layout.sv @@
module tb_text_line_wrap_layout;
  import tlw_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned RandomTarget = 230;
  localparam int unsigned ReportLimit  = 10;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                rx_ready = 1'b0;

  tlw_char_if char_if ();
  tlw_res_if  res_if ();

  assign res_if.ready = rx_ready;

  text_line_wrap_layout dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .char_i     (char_if),
    .res_o      (res_if)
  );

  always #5 clk = ~clk;

  tlw_cfg_t    regs;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] run_x0;
  int          glyphs_in_run;
  bit          layout_halted;
  bit          text_open;
  int          results_now;
  tlw_res_t    pending_results [$];

  int          mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;
  tlw_res_t    got_res;
  tlw_res_t    want_res;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [15:0] sat_sum(int a, int b);
    int s;
    s = a + b;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic tlw_cfg_t make_cfg(int ox, int oy, int ww, int sh, int lg, int gw, int gh);
    tlw_cfg_t c;
    c.origin_x    = 12'(ox);
    c.origin_y    = 12'(oy);
    c.wrap_width  = 12'(ww);
    c.stop_height = 12'(sh);
    c.line_gap    = 8'(lg);
    c.glyph_w     = 7'(gw);
    c.glyph_h     = 7'(gh);
    return c;
  endfunction

  function automatic int pick_field(int maxv);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return maxv;
    return $urandom_range(0, maxv);
  endfunction

  function automatic int pick_cell();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 127;
      2: return 64;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic tlw_cfg_t random_cfg();
    tlw_cfg_t c;
    c.origin_x = 12'(pick_field(4095));
    c.origin_y = 12'(pick_field(4095));
    case ($urandom_range(0, 3))
      0: c.wrap_width = '0;
      1: c.wrap_width = 12'(pick_field(4095));
      default: c.wrap_width = 12'($urandom_range(0, 320));
    endcase
    case ($urandom_range(0, 3))
      0: c.stop_height = '0;
      1: c.stop_height = 12'(pick_field(4095));
      default: c.stop_height = 12'($urandom_range(0, 240));
    endcase
    c.line_gap = 8'(pick_field(255));
    c.glyph_w  = 7'(pick_cell());
    c.glyph_h  = 7'(pick_cell());
    return c;
  endfunction

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 8'($urandom_range(CharSpace, CharTilde));
    if (r < 88) return CharNewline;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic string res_text(tlw_res_t r);
    return $sformatf("kind %0d code %02h slot %0d run_x %0d run_y %0d len %0d last %0b",
                     r.kind, r.glyph_code, r.slot, r.run_x, r.run_y, r.run_length, r.last);
  endfunction

  function automatic void reset_layout_model();
    regs          = make_cfg(0, 0, 0, 0, 0, 6, 12);
    pen_x         = '0;
    pen_y         = '0;
    run_x0        = '0;
    glyphs_in_run = 0;
    layout_halted = 1'b0;
    text_open     = 1'b0;
  endfunction

  function automatic void push_result(tlw_kind_e kind, logic [6:0] code, logic [7:0] slot,
                                      logic [15:0] x, logic [15:0] y, logic [8:0] len);
    tlw_res_t r;
    if (results_now < MaxRes) begin
      r            = '0;
      r.kind       = kind;
      r.glyph_code = code;
      r.slot       = slot;
      r.run_x      = x;
      r.run_y      = y;
      r.run_length = len;
      pending_results.push_back(r);
      results_now++;
    end
  endfunction

  function automatic void flush_run();
    push_result(KIND_FLUSH, '0, '0, run_x0, pen_y, glyphs_in_run[8:0]);
    glyphs_in_run = 0;
  endfunction

  function automatic void halt_layout();
    push_result(KIND_HALT, '0, '0, '0, '0, '0);
    layout_halted = 1'b1;
  endfunction

  function automatic void start_line();
    pen_x  = 16'(regs.origin_x);
    run_x0 = 16'(regs.origin_x);
    pen_y  = sat_sum(int'(pen_y), int'(regs.glyph_h) + int'(regs.line_gap));
  endfunction

  // The height, width and buffer checks run before the byte itself is looked at.
  function automatic void predict_layout(logic [7:0] c, logic eot);
    bit       done;
    tlw_res_t tail;
    results_now = 0;
    if (!text_open) begin
      pen_x         = 16'(regs.origin_x);
      pen_y         = 16'(regs.origin_y);
      run_x0        = 16'(regs.origin_x);
      glyphs_in_run = 0;
      layout_halted = 1'b0;
      text_open     = 1'b1;
    end
    if (!layout_halted) begin
      done = 1'b0;
      while (!done) begin
        if (regs.stop_height != 0 &&
            int'(pen_y) - int'(regs.origin_y) > int'(regs.stop_height)) begin
          halt_layout();
          done = 1'b1;
        end else if (regs.wrap_width != 0 &&
            int'(pen_x) - int'(regs.origin_x) + int'(regs.glyph_w) > int'(regs.wrap_width)) begin
          if (glyphs_in_run == 0) begin
            halt_layout();
            done = 1'b1;
          end else begin
            flush_run();
            start_line();
          end
        end else if (glyphs_in_run >= int'(RunSlotsDef)) begin
          flush_run();
          run_x0 = pen_x;
        end else begin
          if (c == CharNewline) begin
            flush_run();
            start_line();
          end else if (c >= CharSpace && c <= CharTilde) begin
            push_result(KIND_GLYPH, c[6:0], glyphs_in_run[7:0], '0, '0, '0);
            glyphs_in_run++;
            pen_x = sat_sum(int'(pen_x), int'(regs.glyph_w));
          end
          done = 1'b1;
        end
      end
      if (eot && !layout_halted && glyphs_in_run != 0) flush_run();
    end
    if (eot) begin
      glyphs_in_run = 0;
      layout_halted = 1'b0;
      text_open     = 1'b0;
    end
    if (results_now > 0) begin
      tail      = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_res            = '0;
      got_res.kind       = res_if.kind;
      got_res.glyph_code = res_if.glyph_code;
      got_res.slot       = res_if.slot;
      got_res.run_x      = res_if.run_x;
      got_res.run_y      = res_if.run_y;
      got_res.run_length = res_if.run_length;
      got_res.last       = res_if.last;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportLimit) begin
          $display("unexpected result at cycle %0d: %s", cycle_cnt, res_text(got_res));
        end
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportLimit) begin
            $display("result mismatch at cycle %0d", cycle_cnt);
            $display("  expected %s", res_text(want_res));
            $display("  actual   %s", res_text(got_res));
          end
        end
      end
    end
    if (stall_left > 0) begin
      rx_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      rx_ready <= 1'b0;
      stall_left = gap_len();
    end else begin
      rx_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_if.valid       <= 1'b1;
    char_if.char_code   <= c;
    char_if.end_of_text <= eot;
    do @(posedge clk); while (!char_if.ready);
    predict_layout(c, eot);
  endtask

  task automatic send_text(input string s, input bit eot_at_end);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_at_end && i == s.len() - 1);
    end
  endtask

  task automatic wait_drained();
    char_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic load_regs(input tlw_cfg_t c);
    logic [11:0] junk;
    junk = 12'($urandom);
    if ($urandom_range(0, 1) == 0) junk = '0;
    put_reg(CFG_ORIGIN_X, c.origin_x);
    put_reg(CFG_ORIGIN_Y, c.origin_y);
    put_reg(CFG_WRAP_WIDTH, c.wrap_width);
    put_reg(CFG_STOP_HEIGHT, c.stop_height);
    put_reg(CFG_LINE_GAP, {junk[11:8], c.line_gap});
    put_reg(CFG_GLYPH_W, {junk[11:7], c.glyph_w});
    put_reg(CFG_GLYPH_H, {junk[11:7], c.glyph_h});
    put_reg(CfgIdxUnused, CfgDataW'($urandom));
    cfg_we <= 1'b0;
    regs = c;
  endtask

  task automatic test_defaults();
    send_text("A\n~", 1'b1);
    send_text("q", 1'b0);
    send_byte(8'h1F, 1'b1);
  endtask

  task automatic test_wrap_and_stop();
    wait_drained();
    load_regs(make_cfg(4095, 4095, 30, 30, 5, 10, 12));
    send_text(" ~AB", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\n\nZ", 1'b1);
  endtask

  task automatic test_empty_run_halt();
    wait_drained();
    load_regs(make_cfg(0, 0, 5, 0, 0, 10, 12));
    send_text("XY", 1'b1);
    send_text("\n", 1'b1);
  endtask

  task automatic test_config_mid_text();
    wait_drained();
    load_regs(make_cfg(100, 50, 0, 0, 255, 64, 64));
    send_text("ab", 1'b0);
    wait_drained();
    load_regs(make_cfg(10, 50, 100, 0, 255, 64, 64));
    send_text("c\n", 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_long_line();
    int i;
    wait_drained();
    load_regs(make_cfg(4095, 0, 0, 0, 0, 127, 1));
    for (i = 0; i < 490; i++) begin
      send_byte(8'($urandom_range(CharSpace, CharTilde)), i == 489);
    end
  endtask

  task automatic test_tall_column();
    int i;
    wait_drained();
    load_regs(make_cfg(0, 4095, 0, 0, 255, 1, 127));
    for (i = 0; i < 200; i++) begin
      if (i % 8 == 7) send_byte(8'($urandom_range(CharSpace, CharTilde)), i == 199);
      else send_byte(CharNewline, i == 199);
    end
  endtask

  task automatic test_random_text();
    int produced;
    int phase;
    int strings;
    int len;
    int s;
    int i;
    bit close;
    produced = 0;
    phase    = 0;
    while (produced < RandomTarget) begin
      wait_drained();
      if (phase == 0) load_regs(make_cfg(0, 0, 0, 0, 0, 0, 0));
      else if (phase == 1) load_regs(make_cfg(4095, 4095, 4095, 4095, 255, 127, 127));
      else load_regs(random_cfg());
      calm    = ($urandom_range(0, 3) == 0);
      strings = $urandom_range(1, 4);
      for (s = 0; s < strings; s++) begin
        len   = $urandom_range(1, 24);
        close = (s != strings - 1) || ($urandom_range(0, 5) != 0);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 29) == 0) wait_drained();
          send_byte(text_byte(), close && i == len - 1);
          if (results_now > 0) produced++;
        end
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    char_if.valid       <= 1'b0;
    char_if.char_code   <= '0;
    char_if.end_of_text <= 1'b0;
    reset_layout_model();
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_wrap_and_stop();
    test_empty_run_halt();
    test_config_mid_text();
    test_long_line();
    test_tall_column();
    test_random_text();
    wait_drained();
    repeat (20) @(posedge clk);
    mismatch_cnt += pending_results.size();
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
